// ----- hdl/bgyuv_pkg.sv -----
`default_nettype none
package bgyuv_pkg;

   localparam int CSR_W       = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int LUMA_IDX_W  = 24;
   localparam int CHROMA_IDX_W = 22;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [CSR_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
   localparam logic [CSR_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic [7:0]              luma;
      logic [7:0]              chroma_blue;
      logic [7:0]              chroma_red;
      logic                    chroma_valid;
      logic [LUMA_IDX_W-1:0]   luma_index;
      logic [CHROMA_IDX_W-1:0] chroma_index;
      logic                    frame_last;
   } result_type;

   typedef struct packed {
      logic                    chroma_valid;
      logic [LUMA_IDX_W-1:0]   luma_index;
      logic [CHROMA_IDX_W-1:0] chroma_index;
      logic                    frame_last;
   } position_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } sample_type;

endpackage
`default_nettype wire

// ----- hdl/bgyuv_position.sv -----
`default_nettype none
module bgyuv_position
   import bgyuv_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]       csr_wdata,
   input  wire logic                   advance,
   output position_type                position
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int LINE_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WC_W   = ($clog2(MAX_WIDTH + 1) > CSR_W) ? $clog2(MAX_WIDTH + 1) : CSR_W;
   localparam int HC_W   = ($clog2(MAX_HEIGHT + 1) > CSR_W) ? $clog2(MAX_HEIGHT + 1) : CSR_W;
   localparam logic [WC_W-1:0] W_MIN = WC_W'(2);
   localparam logic [WC_W-1:0] W_MAX = WC_W'(MAX_WIDTH);
   localparam logic [HC_W-1:0] H_MIN = HC_W'(1);
   localparam logic [HC_W-1:0] H_MAX = HC_W'(MAX_HEIGHT);

   logic [CSR_W-1:0]        frame_width_ff, frame_width_in;
   logic [CSR_W-1:0]        frame_height_ff, frame_height_in;
   logic [COL_W-1:0]        column_ff, column_in;
   logic [LINE_W-1:0]       line_ff, line_in;
   logic [LUMA_IDX_W-1:0]   luma_pos_ff, luma_pos_in;
   logic [CHROMA_IDX_W-1:0] chroma_pos_ff, chroma_pos_in;

   logic [WC_W-1:0] width_raw, width_clamped, column_next;
   logic [HC_W-1:0] height_raw, height_clamped, line_next;
   logic            chroma, line_end, frame_end;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      width_raw  = WC_W'(frame_width_ff);
      height_raw = HC_W'(frame_height_ff);
      if (width_raw < W_MIN) begin
         width_clamped = W_MIN;
      end else if (width_raw > W_MAX) begin
         width_clamped = W_MAX;
      end else begin
         width_clamped = width_raw;
      end
      if (height_raw < H_MIN) begin
         height_clamped = H_MIN;
      end else if (height_raw > H_MAX) begin
         height_clamped = H_MAX;
      end else begin
         height_clamped = height_raw;
      end
      column_next = WC_W'(column_ff) + WC_W'(1);
      line_next   = HC_W'(line_ff) + HC_W'(1);
      chroma      = !line_ff[0] && !column_ff[0];
      line_end    = column_next >= width_clamped;
      frame_end   = line_end && (line_next >= height_clamped);
   end

   always_comb begin
      position.chroma_valid = chroma;
      position.luma_index   = luma_pos_ff;
      position.chroma_index = chroma ? chroma_pos_ff : '0;
      position.frame_last   = frame_end;
   end

   always_comb begin
      column_in     = column_ff;
      line_in       = line_ff;
      luma_pos_in   = luma_pos_ff;
      chroma_pos_in = chroma_pos_ff;
      if (advance) begin
         if (frame_end) begin
            column_in     = '0;
            line_in       = '0;
            luma_pos_in   = '0;
            chroma_pos_in = '0;
         end else begin
            luma_pos_in = luma_pos_ff + LUMA_IDX_W'(1);
            if (chroma) begin
               chroma_pos_in = chroma_pos_ff + CHROMA_IDX_W'(1);
            end
            if (line_end) begin
               column_in = '0;
               line_in   = line_next[LINE_W-1:0];
            end else begin
               column_in = column_next[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         column_ff       <= '0;
         line_ff         <= '0;
         luma_pos_ff     <= '0;
         chroma_pos_ff   <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         column_ff       <= column_in;
         line_ff         <= line_in;
         luma_pos_ff     <= luma_pos_in;
         chroma_pos_ff   <= chroma_pos_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/bgyuv_color.sv -----
`default_nettype none
module bgyuv_color
   import bgyuv_pkg::*;
(
   input  wire pixel_type  pixel,
   input  wire logic       chroma_valid,
   output sample_type      sample
);

   logic [16:0] y_sum, cb_sum, cr_sum;
   logic [16:0] b_ext, g_ext, r_ext;

   always_comb begin
      b_ext  = 17'(pixel.blue);
      g_ext  = 17'(pixel.green);
      r_ext  = 17'(pixel.red);
      y_sum  = 17'(66) * r_ext + 17'(129) * g_ext + 17'(25) * b_ext;
      cb_sum = 17'(32768) + 17'(112) * b_ext - 17'(38) * r_ext - 17'(74) * g_ext;
      cr_sum = 17'(32768) + 17'(112) * r_ext - 17'(94) * g_ext - 17'(18) * b_ext;
      sample.luma        = y_sum[15:8] + 8'd16;
      sample.chroma_blue = chroma_valid ? cb_sum[15:8] : 8'd0;
      sample.chroma_red  = chroma_valid ? cr_sum[15:8] : 8'd0;
   end

endmodule
`default_nettype wire

// ----- hdl/bgra_to_yuv420_planar_unit.sv -----
// An accepted req beat is registered in the input stage, then in the result register that drives rsp_valid.
// Throughput: one pixel per cycle, set by the input register and the result
// register each loading in every cycle that the next one is free.
// Reset (synchronous, active high): clears both stage valids and the raster
// counters; frame width returns to 1920 and frame height to 1080.
`default_nettype none
module bgra_to_yuv420_planar_unit
   import bgyuv_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]       csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pixel_type              req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output result_type                  rsp_data
);

   logic         s1_valid_ff, s1_valid_in;
   pixel_type    s1_pixel_ff;
   position_type s1_pos_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_data_ff, rsp_data_in;
   position_type position;
   sample_type   sample;
   logic         req_take, s2_load;

   bgyuv_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (req_take),
      .position  (position)
   );

   bgyuv_color u_color (
      .pixel        (s1_pixel_ff),
      .chroma_valid (s1_pos_ff.chroma_valid),
      .sample       (sample)
   );

   always_comb begin
      s2_load   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall = s1_valid_ff && !s2_load;
      req_take  = req_valid && !req_stall;

      s1_valid_in = req_take || (s1_valid_ff && !s2_load);

      rsp_valid_in = s2_load || (rsp_valid_ff && rsp_stall);

      rsp_data_in.luma         = sample.luma;
      rsp_data_in.chroma_blue  = sample.chroma_blue;
      rsp_data_in.chroma_red   = sample.chroma_red;
      rsp_data_in.chroma_valid = s1_pos_ff.chroma_valid;
      rsp_data_in.luma_index   = s1_pos_ff.luma_index;
      rsp_data_in.chroma_index = s1_pos_ff.chroma_index;
      rsp_data_in.frame_last   = s1_pos_ff.frame_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pixel_ff <= req_data;
         s1_pos_ff   <= position;
      end
      if (s2_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_chroma_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.chroma_valid |->
         rsp_data_ff.chroma_index == '0 && rsp_data_ff.chroma_blue == 8'd0 &&
         rsp_data_ff.chroma_red == 8'd0)
      else $error("chroma fields set without chroma");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && req_stall |=> s1_valid_ff && $stable(s1_pixel_ff))
      else $error("input stage lost a stalled beat");

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !s1_valid_ff |=> !rsp_valid_ff)
      else $error("result beat without an item in the input stage");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("valid set after reset");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import bgyuv_pkg::*;

   localparam int MAX_WIDTH    = 4096;
   localparam int MAX_HEIGHT   = 4096;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 500000;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_W-1:0]       csr_wdata;
   logic                   req_valid;
   logic                   req_stall;
   pixel_type              req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   result_type             rsp_data;

   bgra_to_yuv420_planar_unit #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   logic [CSR_W-1:0]        width_setting;
   logic [CSR_W-1:0]        height_setting;
   logic [11:0]             raster_column;
   logic [11:0]             raster_line;
   logic [LUMA_IDX_W-1:0]   luma_position;
   logic [CHROMA_IDX_W-1:0] chroma_position;
   result_type              expected_samples[$];
   int                      error_count = 0;
   int                      cycle_count = 0;
   bit                      sender_idles = 1'b1;
   bit                      receiver_idles = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic result_type convert_pixel(input pixel_type pix);
      int         w;
      int         h;
      int         r;
      int         g;
      int         b;
      int         y_sum;
      int         cb_sum;
      int         cr_sum;
      bit         chroma_on;
      bit         line_end;
      bit         frame_end;
      result_type res;
      w = width_setting;
      h = height_setting;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      r = pix.red;
      g = pix.green;
      b = pix.blue;
      chroma_on = !raster_line[0] && !raster_column[0];
      line_end  = (int'(raster_column) + 1) >= w;
      frame_end = line_end && ((int'(raster_line) + 1) >= h);
      y_sum  = ((66 * r + 129 * g + 25 * b) >>> 8) + 16;
      cb_sum = (32768 + 112 * b - 38 * r - 74 * g) >>> 8;
      cr_sum = (32768 + 112 * r - 94 * g - 18 * b) >>> 8;
      res.luma         = y_sum[7:0];
      res.chroma_blue  = chroma_on ? cb_sum[7:0] : 8'd0;
      res.chroma_red   = chroma_on ? cr_sum[7:0] : 8'd0;
      res.chroma_valid = chroma_on;
      res.luma_index   = luma_position;
      res.chroma_index = chroma_on ? chroma_position : '0;
      res.frame_last   = frame_end;
      if (frame_end) begin
         raster_column   = '0;
         raster_line     = '0;
         luma_position   = '0;
         chroma_position = '0;
      end else begin
         luma_position = luma_position + 1'b1;
         if (chroma_on) chroma_position = chroma_position + 1'b1;
         if (line_end) begin
            raster_column = '0;
            raster_line   = raster_line + 1'b1;
         end else begin
            raster_column = raster_column + 1'b1;
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      result_type want;
      if (reset) begin
         width_setting   = FRAME_WIDTH_RESET;
         height_setting  = FRAME_HEIGHT_RESET;
         raster_column   = '0;
         raster_line     = '0;
         luma_position   = '0;
         chroma_position = '0;
         expected_samples.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH: width_setting = csr_wdata;
               CSR_FRAME_HEIGHT: height_setting = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_samples.push_back(convert_pixel(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: result with no pixel pending, expected none got %p",
                        $time, rsp_data);
               error_count++;
            end else begin
               want = expected_samples.pop_front();
               check_field("luma", want.luma, rsp_data.luma);
               check_field("chroma_blue", want.chroma_blue, rsp_data.chroma_blue);
               check_field("chroma_red", want.chroma_red, rsp_data.chroma_red);
               check_field("chroma_valid", want.chroma_valid, rsp_data.chroma_valid);
               check_field("luma_index", want.luma_index, rsp_data.luma_index);
               check_field("chroma_index", want.chroma_index, rsp_data.chroma_index);
               check_field("frame_last", want.frame_last, rsp_data.frame_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, expected %0d results pending got none",
                  $time, expected_samples.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : sink_stall
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type pix;
      pix.blue  = random_byte();
      pix.green = random_byte();
      pix.red   = random_byte();
      return pix;
   endfunction

   task automatic send_pixel(input pixel_type pix);
      req_valid <= 1'b1;
      req_data  <= pix;
      do @(posedge clock); while (req_stall);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame(input logic [CSR_W-1:0] w, input logic [CSR_W-1:0] h);
      wait_results_done();
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_color_extremes();
      pixel_type colors[10] = '{
         '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF},
         '{8'hFF, 8'h00, 8'h00}, '{8'hAA, 8'h55, 8'hAA},
         '{8'h00, 8'h00, 8'hFF}, '{8'h55, 8'hAA, 8'h55},
         '{8'h00, 8'hFF, 8'hFF}, '{8'h00, 8'hFF, 8'h00},
         '{8'hFF, 8'hFF, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}
      };
      foreach (colors[i]) send_pixel(colors[i]);
   endtask

   task automatic test_frame_shapes();
      // width and height below range clamp up; lands mid-line of the default frame
      set_frame(13'd0, 13'd0);
      repeat (3) send_pixel(random_pixel());
      // odd width: last column of an even line still carries chroma
      set_frame(13'd3, 13'd3);
      repeat (9) send_pixel(random_pixel());
      set_frame(13'd1, 13'd2);
      repeat (2) send_pixel(random_pixel());
      set_frame(13'h1FFF, 13'h1FFF);
      repeat (2) send_pixel(random_pixel());
   endtask

   task automatic test_random_frames();
      logic [CSR_W-1:0] w;
      logic [CSR_W-1:0] h;
      int               beats;
      for (int phase = 0; phase < 14; phase++) begin
         beats = $urandom_range(90, 140);
         if (phase == 0) begin
            w = 13'd2;
            h = 13'd1;
         end else if (phase == 1) begin
            w = 13'd4096;
            h = 13'd4096;
            beats = 40;
         end else if (phase == 2) begin
            w = 13'd2;
            h = 13'd4;
         end else begin
            w = 13'($urandom_range(2, 16));
            h = 13'($urandom_range(1, 6));
         end
         sender_idles   = (phase % 4) != 3;
         receiver_idles = $urandom_range(0, 3) != 0;
         set_frame(w, h);
         repeat (beats) send_pixel(random_pixel());
      end
   endtask

   task automatic test_back_to_back();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      set_frame(13'd6, 13'd4);
      repeat (200) send_pixel(random_pixel());
   endtask

   initial begin
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_color_extremes();
      test_frame_shapes();
      test_random_frames();
      test_back_to_back();
      wait_results_done();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
